// ===== src/chm_pkg.sv =====
// Package: constants, codes, types and sequencer states of the chained hash map.
`default_nettype none
package chm_pkg;

    localparam int MAX_BUCKETS     = 64;
    localparam int CHAIN_DEPTH     = 16;
    localparam int INITIAL_BUCKETS = 3;

    localparam int BKT_W   = $clog2(MAX_BUCKETS);
    localparam int IDX_W   = $clog2(CHAIN_DEPTH);
    localparam int LEN_W   = IDX_W + 1;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 5;
    localparam int SLOT_AW = 1 + BKT_W + IDX_W;
    localparam int LEN_AW  = 1 + BKT_W;

    localparam logic [CFG_W-1:0] GROW_STEP_RST   = CFG_W'(4);
    localparam logic [CFG_W-1:0] CHAIN_LIMIT_RST = CFG_W'(10);

    localparam logic [1:0] CFG_GROW_STEP   = 2'd0;
    localparam logic [1:0] CFG_CHAIN_LIMIT = 2'd1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_CHAIN_FULL = 2'd2;
    localparam logic [1:0] ST_GROW_FAIL  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LEN,
        S_SC,
        S_SC_CHK,
        S_SH,
        S_SH_W,
        S_G_START,
        S_G_OLEN,
        S_G_OLW,
        S_G_ENT,
        S_G_KRD,
        S_G_DIV,
        S_G_NL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [31:0]       dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [BKT_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic               we;
        logic [SLOT_AW-1:0] waddr;
        logic [31:0]        wkey;
        logic [31:0]        wval;
        logic [SLOT_AW-1:0] raddr;
    } t_slot_req;

    typedef struct packed {
        logic              we;
        logic [LEN_AW-1:0] waddr;
        logic [LEN_W-1:0]  wdata;
        logic [LEN_AW-1:0] raddr;
        logic              clr;
        logic              clr_bank;
    } t_len_req;

endpackage
`default_nettype wire

// ===== src/chm_div.sv =====
// Bit-serial signed modulo unit: non-negative remainder of a key by a bucket count.
`default_nettype none
module chm_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire chm_pkg::t_div_req i_req,
    output chm_pkg::t_div_rsp     o_rsp
);
    import chm_pkg::*;

    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [31:0]      r_a;
    logic [CNT_W-1:0] r_r;
    logic [CNT_W-1:0] r_d;
    logic             r_neg;
    logic             r_done;
    logic [BKT_W-1:0] r_rem;

    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] n_r;
    logic [CNT_W-1:0] fin;

    always_comb begin
        trial = {r_r, r_a[31]};
        if (trial >= {1'b0, r_d}) begin
            n_r = CNT_W'(trial - {1'b0, r_d});
        end else begin
            n_r = trial[CNT_W-1:0];
        end
        if (r_neg && (n_r != '0)) begin
            fin = r_d - n_r;
        end else begin
            fin = n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_req.dividend[31];
                r_a    <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                r_r   <= n_r;
                r_a   <= {r_a[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_rem  <= fin[BKT_W-1:0];
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

// ===== src/chm_store.sv =====
// Storage: two banks of key/value slots and two banks of chain lengths with valid bits.
`default_nettype none
module chm_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire chm_pkg::t_slot_req i_slot,
    output logic [31:0]             o_slot_key,
    output logic [31:0]             o_slot_val,
    input  wire chm_pkg::t_len_req  i_len,
    output logic [chm_pkg::LEN_W-1:0] o_len
);
    import chm_pkg::*;

    localparam int SLOTS = 2 ** SLOT_AW;
    localparam int LENS  = 2 ** LEN_AW;

    logic [31:0]      key_mem [SLOTS];
    logic [31:0]      val_mem [SLOTS];
    logic [LEN_W-1:0] len_mem [LENS];
    logic [LENS-1:0]  r_vld;
    logic [LEN_W-1:0] r_len_q;
    logic             r_len_v;

    always_ff @(posedge i_clk) begin
        if (i_slot.we) begin
            key_mem[i_slot.waddr] <= i_slot.wkey;
            val_mem[i_slot.waddr] <= i_slot.wval;
        end
        o_slot_key <= key_mem[i_slot.raddr];
        o_slot_val <= val_mem[i_slot.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_len.we) begin
            len_mem[i_len.waddr] <= i_len.wdata;
        end
        r_len_q <= len_mem[i_len.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_len_v <= 1'b0;
        end else begin
            r_len_v <= r_vld[i_len.raddr];
            for (int k = 0; k < LENS; k++) begin
                if (i_len.clr && (k / MAX_BUCKETS == int'(i_len.clr_bank))) begin
                    r_vld[k] <= 1'b0;
                end else if (i_len.we && (LEN_AW'(k) == i_len.waddr)) begin
                    r_vld[k] <= 1'b1;
                end
            end
        end
    end

    assign o_len = r_len_v ? r_len_q : '0;

endmodule
`default_nettype wire

// ===== src/chained_hash_map_with_growth_top.sv =====
// Top level: sequencer of the chained hash map with growth.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one operation: insert,
//   delete or find, with a signed key and value. Output channel
//   (o_out_valid / i_out_ready) returns status, found value and the bucket
//   count after the operation; one result for every input transfer.
//   Configuration: i_cfg_we writes grow step (index 0) or chain limit
//   (index 1); other indexes are ignored. Write only while idle.
// Flow: every operation first runs the bit-serial modulo unit; an insert
//   then appends at the end of its chain, while a find or delete walks
//   its chain one slot at a time. A delete also shifts the tail of the
//   chain down, one slot at a time. A rehash runs two passes over every
//   stored entry, each entry going through the modulo unit again. One
//   operation is in flight at a time; o_in_ready is high only while the
//   sequencer is idle and reset is released.
// Reset: synchronous, active low. The table comes up empty with three
//   buckets; chain length valid bits clear at once, so no clearing pass.
// Stall: a finished result sits in the output register; the next operation
//   is still accepted, and its result waits until the register is free.
`default_nettype none
module chained_hash_map_with_growth_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_entry_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic signed [31:0] o_found_value,
    output logic [6:0]       o_bucket_total,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [4:0]  i_cfg_data
);
    import chm_pkg::*;

    t_state r_state, n_state;

    logic             r_bank;
    logic [CNT_W-1:0] r_bc, n_bc;
    logic [CFG_W-1:0] r_gs, r_cl;
    logic [1:0]       r_act;
    logic [31:0]      r_key, r_val;
    logic [BKT_W-1:0] r_b, n_b;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_newc, n_newc;
    logic             r_pass, n_pass;
    logic             n_flip;
    logic [CNT_W-1:0] r_ob, n_ob;
    logic [LEN_W-1:0] r_olen, n_olen;
    logic [LEN_W-1:0] r_oi, n_oi;
    logic [31:0]      r_mkey, n_mkey, r_mval, n_mval;
    logic [BKT_W-1:0] r_nb, n_nb;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_found, n_found;

    logic             r_ov;
    logic [1:0]       r_o_status;
    logic [31:0]      r_o_found;
    logic [CNT_W-1:0] r_o_bc;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_slot_req slot_req;
    t_len_req  len_req;
    logic [31:0]      slot_key, slot_val;
    logic [LEN_W-1:0] len_rd;

    logic in_xfer, out_free;
    logic [CNT_W-1:0] grown;
    logic [LEN_W-1:0] i_next;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_ov || i_out_ready;
    assign grown    = r_bc + CNT_W'(r_gs);
    assign i_next   = r_i + LEN_W'(1);

    chm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    chm_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_slot    (slot_req),
        .o_slot_key(slot_key),
        .o_slot_val(slot_val),
        .i_len     (len_req),
        .o_len     (len_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_action inside {ACT_INSERT, ACT_DELETE, ACT_FIND}) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV:    if (div_rsp.done) n_state = S_LEN;
            S_LEN: begin
                if (r_act == ACT_INSERT) begin
                    if (len_rd >= LEN_W'(CHAIN_DEPTH)) begin
                        n_state = S_DONE;
                    end else if ((len_rd + LEN_W'(1)) > LEN_W'(r_cl)) begin
                        n_state = S_G_START;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SC;
                end
            end
            S_SC:     n_state = (r_i >= r_len) ? S_DONE : S_SC_CHK;
            S_SC_CHK: begin
                if (slot_key == r_key) begin
                    if (r_act == ACT_FIND) begin
                        n_state = S_DONE;
                    end else if (slot_val == r_val) begin
                        n_state = S_SH;
                    end else begin
                        n_state = S_SC;
                    end
                end else begin
                    n_state = S_SC;
                end
            end
            S_SH:     n_state = (i_next < r_len) ? S_SH_W : S_DONE;
            S_SH_W:   n_state = S_SH;
            S_G_START: n_state = (grown > CNT_W'(MAX_BUCKETS)) ? S_DONE : S_G_OLEN;
            S_G_OLEN: begin
                if (r_ob == r_bc) begin
                    n_state = r_pass ? S_DONE : S_G_OLEN;
                end else begin
                    n_state = S_G_OLW;
                end
            end
            S_G_OLW:  n_state = S_G_ENT;
            S_G_ENT:  n_state = (r_oi >= r_olen) ? S_G_OLEN : S_G_KRD;
            S_G_KRD:  n_state = S_G_DIV;
            S_G_DIV:  if (div_rsp.done) n_state = S_G_NL;
            S_G_NL: begin
                if (!r_pass && (len_rd >= LEN_W'(CHAIN_DEPTH))) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_G_ENT;
                end
            end
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        div_req  = '0;
        slot_req = '0;
        len_req  = '0;
        n_b      = r_b;
        n_len    = r_len;
        n_i      = r_i;
        n_newc   = r_newc;
        n_pass   = r_pass;
        n_flip   = 1'b0;
        n_bc     = r_bc;
        n_ob     = r_ob;
        n_olen   = r_olen;
        n_oi     = r_oi;
        n_mkey   = r_mkey;
        n_mval   = r_mval;
        n_nb     = r_nb;
        n_status = r_status;
        n_found  = r_found;
        case (r_state)
            S_IDLE: begin
                div_req.start    = in_xfer && (i_action inside {ACT_INSERT, ACT_DELETE, ACT_FIND});
                div_req.dividend = i_key;
                div_req.divisor  = r_bc;
                n_status = ST_NOT_FOUND;
                n_found  = '0;
            end
            S_DIV: begin
                n_b           = div_rsp.rem;
                len_req.raddr = {r_bank, div_rsp.rem};
            end
            S_LEN: begin
                n_len = len_rd;
                n_i   = '0;
                if (r_act == ACT_INSERT) begin
                    if (len_rd >= LEN_W'(CHAIN_DEPTH)) begin
                        n_status = ST_CHAIN_FULL;
                    end else begin
                        slot_req.we    = 1'b1;
                        slot_req.waddr = {r_bank, r_b, len_rd[IDX_W-1:0]};
                        slot_req.wkey  = r_key;
                        slot_req.wval  = r_val;
                        len_req.we     = 1'b1;
                        len_req.waddr  = {r_bank, r_b};
                        len_req.wdata  = len_rd + LEN_W'(1);
                        n_status       = ST_OK;
                    end
                end
            end
            S_SC: begin
                slot_req.raddr = {r_bank, r_b, r_i[IDX_W-1:0]};
            end
            S_SC_CHK: begin
                if ((slot_key == r_key) && (r_act == ACT_FIND)) begin
                    n_found  = slot_val;
                    n_status = ST_OK;
                end else if (!((slot_key == r_key) && (slot_val == r_val))) begin
                    n_i = i_next;
                end
            end
            S_SH: begin
                slot_req.raddr = {r_bank, r_b, i_next[IDX_W-1:0]};
                if (!(i_next < r_len)) begin
                    // drop the last slot of the chain
                    len_req.we    = 1'b1;
                    len_req.waddr = {r_bank, r_b};
                    len_req.wdata = r_len - LEN_W'(1);
                    n_status      = ST_OK;
                end
            end
            S_SH_W: begin
                slot_req.we    = 1'b1;
                slot_req.waddr = {r_bank, r_b, r_i[IDX_W-1:0]};
                slot_req.wkey  = slot_key;
                slot_req.wval  = slot_val;
                n_i            = i_next;
            end
            S_G_START: begin
                if (grown > CNT_W'(MAX_BUCKETS)) begin
                    n_status = ST_GROW_FAIL;
                end else begin
                    n_newc           = grown;
                    n_pass           = 1'b0;
                    n_ob             = '0;
                    len_req.clr      = 1'b1;
                    len_req.clr_bank = !r_bank;
                end
            end
            S_G_OLEN: begin
                len_req.raddr = {r_bank, r_ob[BKT_W-1:0]};
                if (r_ob == r_bc) begin
                    if (r_pass) begin
                        n_flip   = 1'b1;
                        n_bc     = r_newc;
                        n_status = ST_OK;
                    end else begin
                        // restart the walk for the copy pass
                        n_pass           = 1'b1;
                        n_ob             = '0;
                        len_req.clr      = 1'b1;
                        len_req.clr_bank = !r_bank;
                    end
                end
            end
            S_G_OLW: begin
                n_olen = len_rd;
                n_oi   = '0;
            end
            S_G_ENT: begin
                slot_req.raddr = {r_bank, r_ob[BKT_W-1:0], r_oi[IDX_W-1:0]};
                if (r_oi >= r_olen) begin
                    n_ob = r_ob + CNT_W'(1);
                end
            end
            S_G_KRD: begin
                n_mkey           = slot_key;
                n_mval           = slot_val;
                div_req.start    = 1'b1;
                div_req.dividend = slot_key;
                div_req.divisor  = r_newc;
            end
            S_G_DIV: begin
                n_nb          = div_rsp.rem;
                len_req.raddr = {!r_bank, div_rsp.rem};
            end
            S_G_NL: begin
                if (!r_pass && (len_rd >= LEN_W'(CHAIN_DEPTH))) begin
                    n_status = ST_GROW_FAIL;
                end else begin
                    len_req.we    = 1'b1;
                    len_req.waddr = {!r_bank, r_nb};
                    len_req.wdata = len_rd + LEN_W'(1);
                    n_oi          = r_oi + LEN_W'(1);
                    if (r_pass) begin
                        slot_req.we    = 1'b1;
                        slot_req.waddr = {!r_bank, r_nb, len_rd[IDX_W-1:0]};
                        slot_req.wkey  = r_mkey;
                        slot_req.wval  = r_mval;
                    end
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_bc    <= CNT_W'(INITIAL_BUCKETS);
            r_gs    <= GROW_STEP_RST;
            r_cl    <= CHAIN_LIMIT_RST;
            r_ov    <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bc    <= n_bc;
            r_pass  <= n_pass;
            if (n_flip) begin
                r_bank <= !r_bank;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GROW_STEP:   r_gs <= i_cfg_data;
                    CFG_CHAIN_LIMIT: r_cl <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // hold the result until the receiver takes it
            if ((r_state == S_DONE) && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act <= i_action;
            r_key <= i_key;
            r_val <= i_entry_value;
        end
        r_b      <= n_b;
        r_len    <= n_len;
        r_i      <= n_i;
        r_newc   <= n_newc;
        r_ob     <= n_ob;
        r_olen   <= n_olen;
        r_oi     <= n_oi;
        r_mkey   <= n_mkey;
        r_mval   <= n_mval;
        r_nb     <= n_nb;
        r_status <= n_status;
        r_found  <= n_found;
        if ((r_state == S_DONE) && out_free) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_bc     <= r_bc;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_found_value  = r_o_found;
    assign o_bucket_total = r_o_bc;

endmodule
`default_nettype wire
